>>> rtl/core/slf_pkg.sv
// slf_pkg: shared constants and types for the scaled log10 converter.
// Used by slf_front, slf_log2, slf_scale and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slf_pkg;

    // Normalized mantissa, Q1.62 with the leading one at bit 62
    localparam int MANT_W = 63;
    // Square splits the mantissa into a high and a low half
    localparam int SQ_LO_W = 32;
    localparam int SQ_HI_W = MANT_W - SQ_LO_W;

    // Fraction bits of log2, one per squaring step
    localparam int LOG_FRAC = 48;

    // Gain register, signed Q8.8
    localparam int GAIN_W = 16;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd2560;

    // log10(2) in Q0.48, rounded
    localparam int LOG10_2_W = 47;
    localparam logic [LOG10_2_W-1:0] LOG10_2_Q48 = 47'd84732411018728;

    // log10(2) * |gain| in Q.56; |gain| <= 2^15 keeps it below 2^62
    localparam int K_W = 62;

    // Fraction bits of log2 * k: 48 + 48 + 8
    localparam int PROD_FRAC = 104;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_FLOOR  = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/slf_fifo.sv
// slf_fifo: short register queue between the front and the log2/scale back end.
// Depends on nothing; depth and width come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module slf_fifo #(
    parameter int DATA_W = 68,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  n_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("slf_fifo: push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("slf_fifo: pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("slf_fifo: count beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/slf_front.sv
// slf_front: accepts samples, clamps them to the floor and normalizes the result.
// Depends on slf_pkg; feeds slf_fifo.
`timescale 1ns / 1ps
`default_nettype none

module slf_front #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int EXP_W        = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic        [SAMPLE_WIDTH-2:0]    i_floor,
    input  logic                              i_full,
    output logic                              o_push,
    output logic        [slf_pkg::MANT_W-1:0] o_m,
    output logic        [EXP_W-1:0]           o_e
);

    localparam int X_W  = SAMPLE_WIDTH - 1;
    localparam int SH_W = $clog2(slf_pkg::MANT_W);

    logic                       f_adv;
    logic [X_W-1:0]             fl_eff;
    logic [X_W-1:0]             n_x;
    logic [EXP_W-1:0]           n_e;
    logic [SH_W-1:0]            shamt;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic [X_W-1:0]             r_x1;
    logic [X_W-1:0]             r_x2;
    logic [EXP_W-1:0]           r_e2;
    logic [EXP_W-1:0]           r_e3;
    logic [slf_pkg::MANT_W-1:0] r_m3;

    // hold the whole front while the last stage cannot enter the queue
    assign f_adv   = !(r_v3 && i_full);
    assign o_stall = !f_adv;
    assign o_push  = r_v3 && !i_full;
    assign o_m     = r_m3;
    assign o_e     = r_e3;

    // clamp: a zero floor counts as one LSB
    always_comb begin
        fl_eff = (i_floor == '0) ? X_W'(1) : i_floor;
        if (!i_sample[SAMPLE_WIDTH-1] && (i_sample[X_W-1:0] > fl_eff)) begin
            n_x = i_sample[X_W-1:0];
        end else begin
            n_x = fl_eff;
        end
    end

    // leading-one position
    always_comb begin
        n_e = '0;
        for (int i = 0; i < X_W; i++) begin
            if (r_x1[i]) begin
                n_e = EXP_W'(i);
            end
        end
    end

    assign shamt = SH_W'(slf_pkg::MANT_W - 1) - SH_W'(r_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (f_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_x1 <= n_x;
            r_x2 <= r_x1;
            r_e2 <= n_e;
            r_m3 <= slf_pkg::MANT_W'(r_x2) << shamt;
            r_e3 <= r_e2;
        end
    end

    a_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_m3[slf_pkg::MANT_W-1])
        else $error("slf_front: mantissa not normalized");

endmodule

`default_nettype wire

>>> rtl/core/slf_log2.sv
// slf_log2: fraction of log2 of a normalized mantissa by repeated squaring.
// One squaring step per fraction bit, two register stages each. Depends on slf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slf_log2 #(
    parameter int EXP_W = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic [slf_pkg::MANT_W-1:0]          i_m,
    input  logic [EXP_W-1:0]                    i_e,
    output logic                                o_valid,
    output logic [slf_pkg::LOG_FRAC-1:0]        o_frac,
    output logic [EXP_W-1:0]                    o_e
);

    localparam int N    = slf_pkg::LOG_FRAC;
    localparam int MW   = slf_pkg::MANT_W;
    localparam int HW   = slf_pkg::SQ_HI_W;
    localparam int LW   = slf_pkg::SQ_LO_W;
    localparam int SQ_W = 2 * MW;

    logic             v_src  [N];
    logic [MW-1:0]    sq_src [N];
    logic [N-1:0]     f_src  [N];
    logic [EXP_W-1:0] e_src  [N];

    logic             r_va [N];
    logic [2*HW-1:0]  r_hh [N];
    logic [HW+LW-1:0] r_hl [N];
    logic [2*LW-1:0]  r_ll [N];
    logic [N-1:0]     r_fa [N];
    logic [EXP_W-1:0] r_ea [N];

    logic             r_vb [N];
    logic [MW-1:0]    r_mb [N];
    logic [N-1:0]     r_fb [N];
    logic [EXP_W-1:0] r_eb [N];

    logic [SQ_W-1:0]  n_sq [N];
    logic [MW-1:0]    n_mb [N];
    logic [N-1:0]     n_fb [N];

    // step inputs: the queue head for the first step, the previous step after that
    always_comb begin
        v_src[0]  = i_valid;
        sq_src[0] = i_m;
        f_src[0]  = '0;
        e_src[0]  = i_e;
        for (int j = 1; j < N; j++) begin
            v_src[j]  = r_vb[j-1];
            sq_src[j] = r_mb[j-1];
            f_src[j]  = r_fb[j-1];
            e_src[j]  = r_eb[j-1];
        end
    end

    // sum the partial products; a square at or above 2.0 halves and yields a one bit
    always_comb begin
        for (int j = 0; j < N; j++) begin
            n_sq[j] = {r_hh[j], {(2*LW){1'b0}}}
                    + SQ_W'({r_hl[j], {(LW+1){1'b0}}})
                    + SQ_W'(r_ll[j]);
            if (n_sq[j][SQ_W-1]) begin
                n_mb[j] = n_sq[j][SQ_W-1:MW];
            end else begin
                n_mb[j] = n_sq[j][SQ_W-2:MW-1];
            end
            n_fb[j] = {r_fa[j][N-2:0], n_sq[j][SQ_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_va[j] <= 1'b0;
                r_vb[j] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int j = 0; j < N; j++) begin
                r_va[j] <= v_src[j];
                r_vb[j] <= r_va[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < N; j++) begin
                r_hh[j] <= sq_src[j][MW-1:LW] * sq_src[j][MW-1:LW];
                r_hl[j] <= sq_src[j][MW-1:LW] * sq_src[j][LW-1:0];
                r_ll[j] <= sq_src[j][LW-1:0] * sq_src[j][LW-1:0];
                r_fa[j] <= f_src[j];
                r_ea[j] <= e_src[j];
                r_mb[j] <= n_mb[j];
                r_fb[j] <= n_fb[j];
                r_eb[j] <= r_ea[j];
            end
        end
    end

    assign o_valid = r_vb[N-1];
    assign o_frac  = r_fb[N-1];
    assign o_e     = r_eb[N-1];

    a_last_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb[N-1] |-> r_mb[N-1][MW-1])
        else $error("slf_log2: mantissa left its range");

endmodule

`default_nettype wire

>>> rtl/core/slf_scale.sv
// slf_scale: log2 to scaled log10, rounding, offset, saturation and output register.
// Depends on slf_pkg; takes the result of slf_log2.
`timescale 1ns / 1ps
`default_nettype none

module slf_scale #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16,
    parameter int EXP_W        = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic        [slf_pkg::LOG_FRAC-1:0]  i_frac,
    input  logic        [EXP_W-1:0]              i_e,
    input  logic signed [slf_pkg::GAIN_W-1:0]    i_gain,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_offset,
    output logic                                 o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]       o_level
);

    localparam int IPM_W  = $clog2(SAMPLE_WIDTH + FRAC_BITS + 1);
    localparam int IP_W   = IPM_W + 1;
    localparam int LF     = slf_pkg::LOG_FRAC;
    localparam int GW     = slf_pkg::GAIN_W;
    localparam int KW     = slf_pkg::K_W;
    localparam int LM_W   = IPM_W + LF;
    localparam int LM_LO  = LM_W / 2;
    localparam int LM_HI  = LM_W - LM_LO;
    localparam int K_LO   = KW / 2;
    localparam int K_HI   = KW - K_LO;
    localparam int PROD_W = LM_W + KW;
    localparam int SH     = slf_pkg::PROD_FRAC - FRAC_BITS;
    localparam int RM_W   = PROD_W + 1 - SH;
    localparam int RES_W  = ((RM_W > SAMPLE_WIDTH) ? RM_W : SAMPLE_WIDTH) + 2;
    localparam logic [PROD_W:0] RND = {{PROD_W{1'b0}}, 1'b1} << (SH - 1);

    logic [GW-1:0]                         r_gmag;
    logic [slf_pkg::LOG10_2_W+GW-1:0]      k_full;
    logic [KW-1:0]                         r_k;

    logic signed [IP_W-1:0]                ip;
    logic [IPM_W-1:0]                      ip_mag;
    logic [LM_W-1:0]                       n_lmag;
    logic                                  n_neg;
    logic [PROD_W-1:0]                     n_prod;
    logic [PROD_W:0]                       n_rsum;
    logic [RM_W-1:0]                       n_rmag;
    logic [RES_W-1:0]                      n_sv;
    logic [RES_W-1:0]                      n_res;
    logic [SAMPLE_WIDTH-1:0]               n_level;

    logic                                  r_lv;
    logic [LM_W-1:0]                       r_lmag;
    logic                                  r_lneg;
    logic                                  r_p1v;
    logic                                  r_p1neg;
    logic [LM_LO+K_LO-1:0]                 r_p00;
    logic [LM_LO+K_HI-1:0]                 r_p01;
    logic [LM_HI+K_LO-1:0]                 r_p10;
    logic [LM_HI+K_HI-1:0]                 r_p11;
    logic                                  r_p2v;
    logic                                  r_p2neg;
    logic [PROD_W-1:0]                     r_prod;
    logic                                  r_p3v;
    logic [RES_W-1:0]                      r_sv;
    logic                                  r_out_valid;
    logic [SAMPLE_WIDTH-1:0]               r_level;

    // log10(2) * |gain| follows the gain register; it is static while items flow
    assign k_full = slf_pkg::LOG10_2_Q48 * r_gmag;

    always_ff @(posedge i_clk) begin
        r_gmag <= i_gain[GW-1] ? GW'(-i_gain) : GW'(i_gain);
        r_k    <= k_full[KW-1:0];
    end

    // magnitude of log2 in Q.48 and the sign of the scaled result
    always_comb begin
        ip     = $signed(IP_W'(i_e)) - $signed(IP_W'(FRAC_BITS));
        ip_mag = ip[IP_W-1] ? IPM_W'(-ip) : IPM_W'(ip);
        if (ip[IP_W-1]) begin
            n_lmag = {ip_mag, {LF{1'b0}}} - LM_W'(i_frac);
        end else begin
            n_lmag = {ip_mag, {LF{1'b0}}} + LM_W'(i_frac);
        end
        n_neg = ip[IP_W-1] ^ i_gain[GW-1];
    end

    assign n_prod = PROD_W'(r_p00)
                  + (PROD_W'(r_p01) << K_LO)
                  + (PROD_W'(r_p10) << LM_LO)
                  + (PROD_W'(r_p11) << (LM_LO + K_LO));

    // round half away from zero on the magnitude, then apply the sign
    assign n_rsum = {1'b0, r_prod} + RND;
    assign n_rmag = n_rsum[PROD_W:SH];
    assign n_sv   = r_p2neg ? (RES_W'(0) - RES_W'(n_rmag)) : RES_W'(n_rmag);

    // add the offset and clamp to the signed sample range
    always_comb begin
        n_res = r_sv + {{(RES_W-SAMPLE_WIDTH){i_offset[SAMPLE_WIDTH-1]}}, i_offset};
        if (n_res[RES_W-1:SAMPLE_WIDTH-1]
                == {(RES_W-SAMPLE_WIDTH+1){n_res[RES_W-1]}}) begin
            n_level = n_res[SAMPLE_WIDTH-1:0];
        end else if (n_res[RES_W-1]) begin
            n_level = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            n_level = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv        <= 1'b0;
            r_p1v       <= 1'b0;
            r_p2v       <= 1'b0;
            r_p3v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_lv        <= i_valid;
            r_p1v       <= r_lv;
            r_p2v       <= r_p1v;
            r_p3v       <= r_p2v;
            r_out_valid <= r_p3v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lmag  <= n_lmag;
            r_lneg  <= n_neg;
            r_p00   <= r_lmag[LM_LO-1:0] * r_k[K_LO-1:0];
            r_p01   <= r_lmag[LM_LO-1:0] * r_k[KW-1:K_LO];
            r_p10   <= r_lmag[LM_W-1:LM_LO] * r_k[K_LO-1:0];
            r_p11   <= r_lmag[LM_W-1:LM_LO] * r_k[KW-1:K_LO];
            r_p1neg <= r_lneg;
            r_prod  <= n_prod;
            r_p2neg <= r_p1neg;
            r_sv    <= n_sv;
            r_level <= n_level;
        end
    end

    assign o_valid = r_out_valid;
    assign o_level = r_level;

endmodule

`default_nettype wire

>>> rtl/core/scaled_log10_with_floor.sv
// scaled_log10_with_floor: level = gain * log10(max(sample, floor)) + offset, saturated.
// Throughput: one sample per clock while o_stall is low. The pipeline depth is set
//   mostly by the log2 unit's 48 squaring steps at two register stages each.
// Reset (i_rst_n, synchronous, active low) empties all stages and the queue and loads
//   gain 10.0, offset 0 and floor 1 LSB. Uses slf_pkg, slf_front, slf_fifo, slf_log2,
//   slf_scale.
`timescale 1ns / 1ps
`default_nettype none

module scaled_log10_with_floor #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample requests
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_sample,
    // level requests
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]         o_level,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [slf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [SAMPLE_WIDTH-1:0]         i_cfg_data
);

    // Leading-one index of a clamped sample (at most SAMPLE_WIDTH-2)
    localparam int EXP_W  = $clog2(SAMPLE_WIDTH - 1);
    localparam int Q_W    = slf_pkg::MANT_W + EXP_W;
    localparam int Q_DEPTH = 4;
    localparam int X_W    = SAMPLE_WIDTH - 1;

    logic signed [slf_pkg::GAIN_W-1:0]   r_gain;
    logic signed [SAMPLE_WIDTH-1:0]      r_offset;
    logic        [X_W-1:0]               r_floor;

    logic                                f_push;
    logic [slf_pkg::MANT_W-1:0]          f_m;
    logic [EXP_W-1:0]                    f_e;
    logic                                q_full;
    logic                                q_empty;
    logic [Q_W-1:0]                      q_data;
    logic                                b_adv;
    logic                                b_pop;
    logic                                l_valid;
    logic [slf_pkg::LOG_FRAC-1:0]        l_frac;
    logic [EXP_W-1:0]                    l_e;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; an index past the
    // register list is dropped. Writes must arrive only while the datapath is
    // idle, so no item sees a half-updated setting; the block does not enforce it.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= slf_pkg::GAIN_RESET;
            r_offset <= '0;
            r_floor  <= X_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (slf_pkg::t_cfg_idx'(i_cfg_index))
                slf_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[slf_pkg::GAIN_W-1:0];
                slf_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                slf_pkg::CFG_FLOOR:  r_floor  <= i_cfg_data[X_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front: clamp to the floor, find the leading one, normalize to Q1.62.
    // It stalls upstream only when its last stage faces a full queue.
    // ------------------------------------------------------------------
    slf_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .EXP_W        (EXP_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_floor  (r_floor),
        .i_full   (q_full),
        .o_push   (f_push),
        .o_m      (f_m),
        .o_e      (f_e)
    );

    // ------------------------------------------------------------------
    // Queue: decouples the front from the back end, so new samples keep
    // coming in while the output is stalled, until the queue fills.
    // ------------------------------------------------------------------
    slf_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_m, f_e}),
        .i_pop   (b_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // ------------------------------------------------------------------
    // Back end: one lock-step pipeline. Advance whenever the output
    // register is empty or being taken; freeze everything otherwise.
    // An empty queue injects a bubble.
    // ------------------------------------------------------------------
    assign b_adv = !o_valid || !i_stall;
    assign b_pop = b_adv && !q_empty;

    slf_log2 #(
        .EXP_W (EXP_W)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (b_adv),
        .i_valid (!q_empty),
        .i_m     (q_data[Q_W-1:EXP_W]),
        .i_e     (q_data[EXP_W-1:0]),
        .o_valid (l_valid),
        .o_frac  (l_frac),
        .o_e     (l_e)
    );

    // log2 -> gain * log10 with rounding, offset add, saturation and the
    // output register that o_valid / o_level come from
    slf_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .EXP_W        (EXP_W)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (b_adv),
        .i_valid  (l_valid),
        .i_frac   (l_frac),
        .i_e      (l_e),
        .i_gain   (r_gain),
        .i_offset (r_offset),
        .o_valid  (o_valid),
        .o_level  (o_level)
    );

endmodule

`default_nettype wire
